// ----- rtl/area_average_matrix_resize_unit_assert.svh -----
// Assertion macros shared by the resize unit RTL.
`ifndef AREA_AVERAGE_MATRIX_RESIZE_UNIT_ASSERT_SVH
`define AREA_AVERAGE_MATRIX_RESIZE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AAMR_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AAMR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/aamr_pkg.sv -----
// Package with the sizes, types and helper functions of the resize unit.
`timescale 1ns / 1ps

package aamr_pkg;

   localparam int MAX_ROWS    = 64;
   localparam int MAX_COLS    = 64;
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 8;

   // Field widths fixed by the interface definition.
   localparam int CFG_BITS = 7;
   localparam int ROW_BITS = 6;
   localparam int COL_BITS = 6;

   localparam int MAX_DIM    = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
   localparam int DIM_BITS   = $clog2(MAX_DIM + 1);
   localparam int AX_BITS    = $clog2(MAX_DIM * MAX_DIM + 1);
   localparam int WT_BITS    = 2 * DIM_BITS;
   localparam int DEPTH      = MAX_ROWS * MAX_COLS;
   localparam int ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DEN_BITS   = $clog2(DEPTH + 1);
   localparam int ACC_BITS   = SAMPLE_BITS + DEN_BITS;
   localparam int NUM_BITS   = ACC_BITS + FRAC_BITS + 1;
   localparam int CNT_BITS   = $clog2(NUM_BITS + 1);
   localparam int VALUE_BITS = SAMPLE_BITS + FRAC_BITS;

   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 4;

   typedef enum logic [1:0] {
      REG_OLD_ROWS = 2'd0,
      REG_OLD_COLS = 2'd1,
      REG_NEW_ROWS = 2'd2,
      REG_NEW_COLS = 2'd3
   } reg_index_type;

   typedef enum logic {
      KIND_WRITE = 1'b0,
      KIND_READ  = 1'b1
   } kind_type;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [VALUE_BITS-1:0]  value_type;
   typedef logic [DIM_BITS-1:0]           dim_type;
   typedef logic [AX_BITS-1:0]            ax_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // A dimension register value of zero acts as one; anything above the maximum is clamped.
   function automatic dim_type fit_dim(input logic [CFG_BITS-1:0] v, input int maxv);
      int d;
      d = int'(v);
      if (d < 1) d = 1;
      if (d > maxv) d = maxv;
      return DIM_BITS'(d);
   endfunction

   // Overlap of two cells on a common axis, each given by its low edge and span.
   function automatic dim_type overlap(input ax_type alo, input dim_type as_span,
                                       input ax_type blo, input dim_type bs_span);
      ax_type ahi;
      ax_type bhi;
      ax_type lo;
      ax_type hi;
      ahi = alo + AX_BITS'(as_span);
      bhi = blo + AX_BITS'(bs_span);
      lo  = (alo > blo) ? alo : blo;
      hi  = (ahi < bhi) ? ahi : bhi;
      return (hi > lo) ? DIM_BITS'(hi - lo) : '0;
   endfunction

endpackage

// ----- rtl/aamr_ifs.sv -----
// Handshake interfaces for the request and response channels of the resize unit.
`timescale 1ns / 1ps

interface aamr_req_if;
   logic                          valid;
   logic                          ready;
   aamr_pkg::kind_type            kind;
   logic [aamr_pkg::ROW_BITS-1:0] row;
   logic [aamr_pkg::COL_BITS-1:0] col;
   aamr_pkg::sample_type          sample;

   modport source (output valid, kind, row, col, sample, input ready);
   modport sink   (input valid, kind, row, col, sample, output ready);
endinterface

interface aamr_rsp_if;
   logic                valid;
   logic                ready;
   aamr_pkg::value_type value;
   logic                range_error;

   modport source (output valid, value, range_error, input ready);
   modport sink   (input valid, value, range_error, output ready);
endinterface

// ----- rtl/aamr_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module aamr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/aamr_div.sv -----
// Bit-serial restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module aamr_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [aamr_pkg::NUM_BITS-1:0] numer,
   input  logic [aamr_pkg::DEN_BITS-1:0] denom,
   output logic [aamr_pkg::NUM_BITS-1:0] quot,
   output aamr_pkg::div_stat_type        stat
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [aamr_pkg::CNT_BITS-1:0] count_ff, count_in;
   logic [aamr_pkg::NUM_BITS-1:0] num_ff, num_in;
   logic [aamr_pkg::DEN_BITS-1:0] rem_ff, rem_in;
   logic [aamr_pkg::DEN_BITS-1:0] den_ff, den_in;
   logic [aamr_pkg::DEN_BITS:0]   shifted;
   logic [aamr_pkg::DEN_BITS:0]   diff;
   logic                          ge;
   logic                          last_step;

   assign shifted   = {rem_ff, num_ff[aamr_pkg::NUM_BITS-1]};
   assign diff      = shifted - {1'b0, den_ff};
   assign ge        = shifted >= {1'b0, den_ff};
   assign last_step = count_ff == aamr_pkg::CNT_BITS'(aamr_pkg::NUM_BITS - 1);

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         num_in   = numer;
         rem_in   = '0;
         den_in   = denom;
      end else if (busy_ff) begin
         // The numerator register shifts out dividend bits and takes in quotient bits.
         num_in   = {num_ff[aamr_pkg::NUM_BITS-2:0], ge};
         rem_in   = ge ? diff[aamr_pkg::DEN_BITS-1:0] : shifted[aamr_pkg::DEN_BITS-1:0];
         count_in = count_ff + 1'b1;
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quot      = num_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ----- rtl/area_average_matrix_resize_unit.sv -----
// Area-averaging matrix resize unit: sample store, multiply-accumulate walk and divider.
//
//   channel   direction   handshake        payload
//   req       in          valid / ready    kind, row, col, sample
//   rsp       out         valid / ready    value, range_error
//   csr       in          APB write/read   old_rows, old_cols, new_rows, new_cols
//
// A write item or an out-of-range read goes from acceptance to the done state and from there
// into the output register once that register is free. An in-range read walks all
// old_rows * old_cols stored samples, one a cycle through a single multiply-accumulate, drains
// the product pipeline, then runs a 38-step bit-serial divider and passes its result through
// the done state in the same way. The next item is accepted once the result sits in the output
// register, even while it waits to be taken. Reset sets the dimensions to one and clears control
// state; the sample store is not cleared.
`timescale 1ns / 1ps
`include "area_average_matrix_resize_unit_assert.svh"

module area_average_matrix_resize_unit (
   input  logic                               clock,
   input  logic                               reset,
   aamr_req_if.sink                           req,
   aamr_rsp_if.source                         rsp,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [aamr_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [aamr_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [aamr_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_WALK  = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   localparam logic [aamr_pkg::NUM_BITS-1:0] SAT_LO =
      aamr_pkg::NUM_BITS'(1) << (aamr_pkg::SAMPLE_BITS - 1 + aamr_pkg::FRAC_BITS);
   localparam logic [aamr_pkg::NUM_BITS-1:0] SAT_HI =
      ((aamr_pkg::NUM_BITS'(1) << (aamr_pkg::SAMPLE_BITS - 1)) - aamr_pkg::NUM_BITS'(1))
      << aamr_pkg::FRAC_BITS;

   // Configuration registers.
   aamr_pkg::dim_type old_rows_ff, old_cols_ff, new_rows_ff, new_cols_ff;
   logic              csr_wr;
   aamr_pkg::reg_index_type csr_index;

   // Sequencer state.
   state_type                     state_ff, state_in;
   aamr_pkg::dim_type             i_ff, i_in;
   aamr_pkg::dim_type             k_ff, k_in;
   aamr_pkg::ax_type              row_lo_ff, row_lo_in;
   aamr_pkg::ax_type              col_lo_ff, col_lo_in;
   aamr_pkg::ax_type              out_r_lo_ff, out_r_lo_in;
   aamr_pkg::ax_type              out_c_lo_ff, out_c_lo_in;
   logic [aamr_pkg::DEN_BITS-1:0] den_ff, den_in;
   logic signed [aamr_pkg::ACC_BITS-1:0] acc_ff, acc_in;
   logic                          neg_ff, neg_in;
   aamr_pkg::value_type           res_value_ff, res_value_in;
   logic                          res_err_ff, res_err_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   aamr_pkg::value_type           rsp_value_ff, rsp_value_in;
   logic                          rsp_err_ff, rsp_err_in;

   // Multiply-accumulate pipeline.
   logic                                  s1_act_ff, s1_act_in;
   logic                                  s2_act_ff;
   logic                                  s3_act_ff;
   aamr_pkg::dim_type                     ovr_ff, ovc_ff;
   logic [aamr_pkg::WT_BITS-1:0]          wt_ff;
   aamr_pkg::sample_type                  samp_ff;
   logic signed [aamr_pkg::ACC_BITS-1:0]  prod_ff;

   logic                                  req_fire;
   logic                                  in_range_wr;
   logic                                  in_range_rd;
   logic                                  last_col;
   logic                                  last_row;
   logic                                  pipe_empty;
   logic                                  out_free;
   logic                                  walk_idx_ok;
   aamr_pkg::dim_type                     ovr, ovc;
   logic                                  ram_we;
   logic [aamr_pkg::ADDR_BITS-1:0]        ram_waddr;
   logic [aamr_pkg::ADDR_BITS-1:0]        ram_raddr;
   logic [aamr_pkg::SAMPLE_BITS-1:0]      ram_rdata;
   logic [aamr_pkg::ACC_BITS-1:0]         mag;
   logic                                  div_start;
   logic [aamr_pkg::NUM_BITS-1:0]         div_numer;
   logic [aamr_pkg::NUM_BITS-1:0]         div_quot;
   aamr_pkg::div_stat_type                div_stat;
   logic [aamr_pkg::NUM_BITS-1:0]         q_sat;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = aamr_pkg::reg_index_type'(csr_paddr[aamr_pkg::CSR_ADDR_BITS-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         old_rows_ff <= aamr_pkg::DIM_BITS'(1);
         old_cols_ff <= aamr_pkg::DIM_BITS'(1);
         new_rows_ff <= aamr_pkg::DIM_BITS'(1);
         new_cols_ff <= aamr_pkg::DIM_BITS'(1);
      end else if (csr_wr) begin
         case (csr_index)
            aamr_pkg::REG_OLD_ROWS: old_rows_ff <= aamr_pkg::fit_dim(
               csr_pwdata[aamr_pkg::CFG_BITS-1:0], aamr_pkg::MAX_ROWS);
            aamr_pkg::REG_OLD_COLS: old_cols_ff <= aamr_pkg::fit_dim(
               csr_pwdata[aamr_pkg::CFG_BITS-1:0], aamr_pkg::MAX_COLS);
            aamr_pkg::REG_NEW_ROWS: new_rows_ff <= aamr_pkg::fit_dim(
               csr_pwdata[aamr_pkg::CFG_BITS-1:0], aamr_pkg::MAX_ROWS);
            aamr_pkg::REG_NEW_COLS: new_cols_ff <= aamr_pkg::fit_dim(
               csr_pwdata[aamr_pkg::CFG_BITS-1:0], aamr_pkg::MAX_COLS);
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         aamr_pkg::REG_OLD_ROWS: csr_prdata = aamr_pkg::CSR_DATA_BITS'(old_rows_ff);
         aamr_pkg::REG_OLD_COLS: csr_prdata = aamr_pkg::CSR_DATA_BITS'(old_cols_ff);
         aamr_pkg::REG_NEW_ROWS: csr_prdata = aamr_pkg::CSR_DATA_BITS'(new_rows_ff);
         aamr_pkg::REG_NEW_COLS: csr_prdata = aamr_pkg::CSR_DATA_BITS'(new_cols_ff);
         default:                csr_prdata = '0;
      endcase
   end

   // ---------------- sample store ----------------
   assign req.ready   = state_ff == ST_IDLE;
   assign req_fire    = req.valid & req.ready;
   assign in_range_wr = (aamr_pkg::DIM_BITS'(req.row) < old_rows_ff) &&
                        (aamr_pkg::DIM_BITS'(req.col) < old_cols_ff);
   assign in_range_rd = (aamr_pkg::DIM_BITS'(req.row) < new_rows_ff) &&
                        (aamr_pkg::DIM_BITS'(req.col) < new_cols_ff);
   assign ram_we      = req_fire && (req.kind == aamr_pkg::KIND_WRITE) && in_range_wr;
   assign ram_waddr   = aamr_pkg::ADDR_BITS'(req.row) *
                        aamr_pkg::ADDR_BITS'(aamr_pkg::MAX_COLS) +
                        aamr_pkg::ADDR_BITS'(req.col);
   assign ram_raddr   = aamr_pkg::ADDR_BITS'(i_ff) *
                        aamr_pkg::ADDR_BITS'(aamr_pkg::MAX_COLS) +
                        aamr_pkg::ADDR_BITS'(k_ff);

   aamr_ram #(
      .WIDTH (aamr_pkg::SAMPLE_BITS),
      .DEPTH (aamr_pkg::DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (req.sample),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // ---------------- walk and accumulate ----------------
   assign ovr = aamr_pkg::overlap(row_lo_ff, new_rows_ff, out_r_lo_ff, old_rows_ff);
   assign ovc = aamr_pkg::overlap(col_lo_ff, new_cols_ff, out_c_lo_ff, old_cols_ff);

   assign last_col    = k_ff == (old_cols_ff - aamr_pkg::DIM_BITS'(1));
   assign last_row    = i_ff == (old_rows_ff - aamr_pkg::DIM_BITS'(1));
   assign pipe_empty  = !s1_act_ff && !s2_act_ff && !s3_act_ff;
   assign out_free    = !rsp_valid_ff || rsp.ready;
   assign walk_idx_ok = (i_ff < old_rows_ff) && (k_ff < old_cols_ff);

   assign mag       = acc_ff[aamr_pkg::ACC_BITS-1] ? aamr_pkg::ACC_BITS'(-acc_ff)
                                                   : aamr_pkg::ACC_BITS'(acc_ff);
   // Adding half the divisor before dividing gives round to nearest, ties away from zero.
   assign div_numer = (aamr_pkg::NUM_BITS'(mag) << aamr_pkg::FRAC_BITS) +
                      aamr_pkg::NUM_BITS'(den_ff >> 1);
   assign div_start = (state_ff == ST_DRAIN) && pipe_empty;

   aamr_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (den_ff),
      .quot  (div_quot),
      .stat  (div_stat)
   );

   always_comb begin
      if (neg_ff) begin
         q_sat = (div_quot > SAT_LO) ? SAT_LO : div_quot;
      end else begin
         q_sat = (div_quot > SAT_HI) ? SAT_HI : div_quot;
      end
   end

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      row_lo_in    = row_lo_ff;
      col_lo_in    = col_lo_ff;
      out_r_lo_in  = out_r_lo_ff;
      out_c_lo_in  = out_c_lo_ff;
      den_in       = den_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      res_value_in = res_value_ff;
      res_err_in   = res_err_ff;
      s1_act_in    = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp.ready;
      rsp_value_in = rsp_value_ff;
      rsp_err_in   = rsp_err_ff;

      if (s3_act_ff) begin
         acc_in = acc_ff + prod_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_value_in = '0;
               if (req.kind == aamr_pkg::KIND_WRITE) begin
                  res_err_in = !in_range_wr;
                  state_in   = ST_DONE;
               end else if (!in_range_rd) begin
                  res_err_in = 1'b1;
                  state_in   = ST_DONE;
               end else begin
                  res_err_in  = 1'b0;
                  i_in        = '0;
                  k_in        = '0;
                  row_lo_in   = '0;
                  col_lo_in   = '0;
                  out_r_lo_in = aamr_pkg::AX_BITS'(req.row) * aamr_pkg::AX_BITS'(old_rows_ff);
                  out_c_lo_in = aamr_pkg::AX_BITS'(req.col) * aamr_pkg::AX_BITS'(old_cols_ff);
                  den_in      = aamr_pkg::DEN_BITS'(old_rows_ff) *
                                aamr_pkg::DEN_BITS'(old_cols_ff);
                  acc_in      = '0;
                  state_in    = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            // Samples with no overlap are skipped so that their contents never matter.
            s1_act_in = (ovr != '0) && (ovc != '0);
            if (last_col) begin
               k_in      = '0;
               col_lo_in = '0;
               i_in      = i_ff + aamr_pkg::DIM_BITS'(1);
               row_lo_in = row_lo_ff + aamr_pkg::AX_BITS'(new_rows_ff);
               if (last_row) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               k_in      = k_ff + aamr_pkg::DIM_BITS'(1);
               col_lo_in = col_lo_ff + aamr_pkg::AX_BITS'(new_cols_ff);
            end
         end
         ST_DRAIN: begin
            if (pipe_empty) begin
               neg_in   = acc_ff[aamr_pkg::ACC_BITS-1];
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               res_value_in = aamr_pkg::VALUE_BITS'(neg_ff ? (aamr_pkg::NUM_BITS'(0) - q_sat)
                                                           : q_sat);
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_value_ff;
               rsp_err_in   = res_err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         s1_act_ff    <= 1'b0;
         s2_act_ff    <= 1'b0;
         s3_act_ff    <= 1'b0;
         i_ff         <= '0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_act_ff    <= s1_act_in;
         s2_act_ff    <= s1_act_ff;
         s3_act_ff    <= s2_act_ff;
         i_ff         <= i_in;
         k_ff         <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      row_lo_ff    <= row_lo_in;
      col_lo_ff    <= col_lo_in;
      out_r_lo_ff  <= out_r_lo_in;
      out_c_lo_ff  <= out_c_lo_in;
      den_ff       <= den_in;
      acc_ff       <= acc_in;
      neg_ff       <= neg_in;
      res_value_ff <= res_value_in;
      res_err_ff   <= res_err_in;
      rsp_value_ff <= rsp_value_in;
      rsp_err_ff   <= rsp_err_in;
      // The read data of the store lines up with the overlaps registered alongside it.
      ovr_ff       <= ovr;
      ovc_ff       <= ovc;
      wt_ff        <= aamr_pkg::WT_BITS'(ovr_ff) * aamr_pkg::WT_BITS'(ovc_ff);
      samp_ff      <= aamr_pkg::sample_type'(ram_rdata);
      prod_ff      <= aamr_pkg::ACC_BITS'(samp_ff) *
                      aamr_pkg::ACC_BITS'($signed({1'b0, wt_ff}));
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.value       = rsp_value_ff;
   assign rsp.range_error = rsp_err_ff;

   // ---------------- assertions ----------------
   `AAMR_ASSERT_NEXT(a_div_starts, div_start, div_stat.busy, "divider did not start")
   `AAMR_ASSERT_SAME(a_busy_not_ready, div_stat.busy, !req.ready, "ready while dividing")
   `AAMR_ASSERT_SAME(a_walk_in_range, state_ff == ST_WALK, walk_idx_ok, "walk index out of range")
   `AAMR_ASSERT_SAME(a_error_zero, rsp.valid && rsp.range_error, rsp.value == '0, "value on error")

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the area-averaging matrix resize unit.
`timescale 1ns / 1ps

module testbench;

   logic clock = 1'b0;
   logic reset;

   logic                               csr_psel;
   logic                               csr_penable;
   logic                               csr_pwrite;
   logic [aamr_pkg::CSR_ADDR_BITS-1:0] csr_paddr;
   logic [aamr_pkg::CSR_DATA_BITS-1:0] csr_pwdata;
   logic [aamr_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                               csr_pready;

   aamr_req_if req_ch ();
   aamr_rsp_if rsp_ch ();

   area_average_matrix_resize_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   typedef struct packed {
      aamr_pkg::value_type value;
      logic                range_error;
   } element_type;

   typedef struct packed {
      bit                                 is_cfg;
      aamr_pkg::reg_index_type            reg_sel;
      logic [aamr_pkg::CSR_DATA_BITS-1:0] reg_data;
      aamr_pkg::kind_type                 kind;
      logic [aamr_pkg::ROW_BITS-1:0]      row;
      logic [aamr_pkg::COL_BITS-1:0]      col;
      aamr_pkg::sample_type               sample;
      bit                                 typed;
      aamr_pkg::value_type                value;
      logic                               range_error;
   } directed_step_type;

   // Shadow of the sample store and the dimensions currently in force.
   aamr_pkg::sample_type shadow_store [aamr_pkg::DEPTH];
   bit                   shadow_written [aamr_pkg::DEPTH];
   int                   old_rows_in_use;
   int                   old_cols_in_use;
   int                   new_rows_in_use;
   int                   new_cols_in_use;

   element_type awaited_elements [$];
   int          send_idle_pct;
   int          recv_stall_pct;
   bit          hold_request;
   int          failures;

   always #10 clock = ~clock;

   function automatic int clamp_dim(input logic [aamr_pkg::CSR_DATA_BITS-1:0] data,
                                    input int maxv);
      int d;
      d = int'(data[aamr_pkg::CFG_BITS-1:0]);
      if (d < 1) d = 1;
      if (d > maxv) d = maxv;
      return d;
   endfunction

   // Length shared by cell a and cell b on an axis where they span a_span and b_span units.
   function automatic int shared_span(input int a, input int a_span, input int b,
                                      input int b_span);
      int lo;
      int hi;
      lo = (a * a_span > b * b_span) ? a * a_span : b * b_span;
      hi = (a * a_span + a_span < b * b_span + b_span) ? a * a_span + a_span
                                                       : b * b_span + b_span;
      return (hi > lo) ? hi - lo : 0;
   endfunction

   function automatic aamr_pkg::value_type resized_element(input int r, input int c);
      longint acc;
      longint den;
      longint mag;
      longint quot;
      longint rem;
      longint res;
      longint limit;
      int     wr;
      int     wc;
      bit     neg;
      acc = 0;
      for (int i = 0; i < old_rows_in_use; i++) begin
         wr = shared_span(i, new_rows_in_use, r, old_rows_in_use);
         if (wr != 0) begin
            for (int k = 0; k < old_cols_in_use; k++) begin
               wc = shared_span(k, new_cols_in_use, c, old_cols_in_use);
               acc += longint'(shadow_store[i * aamr_pkg::MAX_COLS + k]) * longint'(wr * wc);
            end
         end
      end
      // Round the magnitude to nearest, so that ties go away from zero.
      den  = longint'(old_rows_in_use * old_cols_in_use);
      neg  = acc < 0;
      mag  = neg ? -acc : acc;
      quot = mag / den;
      rem  = mag % den;
      res  = (quot << aamr_pkg::FRAC_BITS) + ((rem << aamr_pkg::FRAC_BITS) + den / 2) / den;
      if (neg) begin
         limit = longint'(1) << (aamr_pkg::SAMPLE_BITS - 1 + aamr_pkg::FRAC_BITS);
         if (res > limit) res = limit;
         res = -res;
      end else begin
         limit = ((longint'(1) << (aamr_pkg::SAMPLE_BITS - 1)) - 1) << aamr_pkg::FRAC_BITS;
         if (res > limit) res = limit;
      end
      return aamr_pkg::value_type'(res);
   endfunction

   function automatic element_type step_matrix(input aamr_pkg::kind_type k, input int r,
                                               input int c, input aamr_pkg::sample_type s);
      element_type outcome;
      outcome = '0;
      if (k == aamr_pkg::KIND_WRITE) begin
         if (r < old_rows_in_use && c < old_cols_in_use) begin
            shadow_store[r * aamr_pkg::MAX_COLS + c]   = s;
            shadow_written[r * aamr_pkg::MAX_COLS + c] = 1'b1;
         end else begin
            outcome.range_error = 1'b1;
         end
      end else if (r < new_rows_in_use && c < new_cols_in_use) begin
         outcome.value = resized_element(r, c);
      end else begin
         outcome.range_error = 1'b1;
      end
      return outcome;
   endfunction

   function automatic directed_step_type item_step(input aamr_pkg::kind_type k, input int r,
                                                   input int c, input int s, input bit typed,
                                                   input int v, input bit e);
      directed_step_type st;
      st             = '0;
      st.kind        = k;
      st.row         = aamr_pkg::ROW_BITS'(r);
      st.col         = aamr_pkg::COL_BITS'(c);
      st.sample      = aamr_pkg::sample_type'(s);
      st.typed       = typed;
      st.value       = aamr_pkg::value_type'(v);
      st.range_error = e;
      return st;
   endfunction

   function automatic directed_step_type reg_step(input aamr_pkg::reg_index_type idx,
                                                  input int data);
      directed_step_type st;
      st          = '0;
      st.is_cfg   = 1'b1;
      st.reg_sel  = idx;
      st.reg_data = aamr_pkg::CSR_DATA_BITS'(data);
      return st;
   endfunction

   // APB write: setup phase, access phase, then a quiet phase with the select low.
   task automatic write_reg(input aamr_pkg::reg_index_type idx,
                            input logic [aamr_pkg::CSR_DATA_BITS-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= aamr_pkg::CSR_ADDR_BITS'(int'(idx) * 4);
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         aamr_pkg::REG_OLD_ROWS: old_rows_in_use = clamp_dim(data, aamr_pkg::MAX_ROWS);
         aamr_pkg::REG_OLD_COLS: old_cols_in_use = clamp_dim(data, aamr_pkg::MAX_COLS);
         aamr_pkg::REG_NEW_ROWS: new_rows_in_use = clamp_dim(data, aamr_pkg::MAX_ROWS);
         aamr_pkg::REG_NEW_COLS: new_cols_in_use = clamp_dim(data, aamr_pkg::MAX_COLS);
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_item(input aamr_pkg::kind_type k,
                            input logic [aamr_pkg::ROW_BITS-1:0] r,
                            input logic [aamr_pkg::COL_BITS-1:0] c,
                            input aamr_pkg::sample_type s,
                            input bit typed = 1'b0, input aamr_pkg::value_type tv = '0,
                            input logic te = 1'b0);
      element_type outcome;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.kind   <= k;
      req_ch.row    <= r;
      req_ch.col    <= c;
      req_ch.sample <= s;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      outcome = step_matrix(k, int'(r), int'(c), s);
      if (typed) begin
         outcome.value       = tv;
         outcome.range_error = te;
      end
      awaited_elements.push_back(outcome);
   endtask

   task automatic await_drain();
      req_ch.valid <= 1'b0;
      while (awaited_elements.size() != 0) @(posedge clock);
   endtask

   // Writes every sample of the region in use that has never been written.
   task automatic fill_matrix();
      for (int i = 0; i < old_rows_in_use; i++) begin
         for (int k = 0; k < old_cols_in_use; k++) begin
            if (!shadow_written[i * aamr_pkg::MAX_COLS + k])
               send_item(aamr_pkg::KIND_WRITE, aamr_pkg::ROW_BITS'(i), aamr_pkg::COL_BITS'(k),
                         aamr_pkg::sample_type'($urandom));
         end
      end
   endtask

   task automatic random_item();
      int                            pick;
      aamr_pkg::kind_type            k;
      logic [aamr_pkg::ROW_BITS-1:0] r;
      logic [aamr_pkg::COL_BITS-1:0] c;
      aamr_pkg::sample_type          s;
      pick = $urandom_range(99);
      s    = aamr_pkg::sample_type'($urandom);
      if ($urandom_range(9) == 0) s = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      if (pick < 45) begin
         k = aamr_pkg::KIND_READ;
         r = aamr_pkg::ROW_BITS'($urandom_range(new_rows_in_use - 1));
         c = aamr_pkg::COL_BITS'($urandom_range(new_cols_in_use - 1));
      end else if (pick < 80) begin
         k = aamr_pkg::KIND_WRITE;
         r = aamr_pkg::ROW_BITS'($urandom_range(old_rows_in_use - 1));
         c = aamr_pkg::COL_BITS'($urandom_range(old_cols_in_use - 1));
      end else begin
         k = aamr_pkg::kind_type'(1'($urandom_range(1)));
         r = aamr_pkg::ROW_BITS'($urandom);
         c = aamr_pkg::COL_BITS'($urandom);
      end
      send_item(k, r, c, s);
   endtask

   task automatic run_phase(input int o_r, input int o_c, input int n_r, input int n_c,
                            input int idle_pct, input int stall_pct, input int count,
                            input bit squeeze);
      await_drain();
      write_reg(aamr_pkg::REG_OLD_ROWS, aamr_pkg::CSR_DATA_BITS'(o_r));
      write_reg(aamr_pkg::REG_OLD_COLS, aamr_pkg::CSR_DATA_BITS'(o_c));
      write_reg(aamr_pkg::REG_NEW_ROWS, aamr_pkg::CSR_DATA_BITS'(n_r));
      write_reg(aamr_pkg::REG_NEW_COLS, aamr_pkg::CSR_DATA_BITS'(n_c));
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      if (squeeze) hold_request = 1'b1;
      fill_matrix();
      repeat (count) random_item();
   endtask

   // Response side: random back-pressure and the comparison against the oldest expectation.
   initial begin
      int          hold_left;
      element_type want;
      hold_left   = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (awaited_elements.size() == 0) begin
               failures++;
               $display("%0t: unexpected item, value %0d range_error %b", $time,
                        rsp_ch.value, rsp_ch.range_error);
            end else begin
               want = awaited_elements.pop_front();
               if (rsp_ch.value !== want.value) begin
                  failures++;
                  $display("%0t: value expected %0d, actual %0d", $time, want.value,
                           rsp_ch.value);
               end
               if (rsp_ch.range_error !== want.range_error) begin
                  failures++;
                  $display("%0t: range_error expected %b, actual %b", $time,
                           want.range_error, rsp_ch.range_error);
               end
            end
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin
      directed_step_type directed_steps [$];
      reset         <= 1'b1;
      csr_psel      <= 1'b0;
      csr_penable   <= 1'b0;
      csr_pwrite    <= 1'b0;
      csr_paddr     <= '0;
      csr_pwdata    <= '0;
      req_ch.valid  <= 1'b0;
      req_ch.kind   <= aamr_pkg::KIND_WRITE;
      req_ch.row    <= '0;
      req_ch.col    <= '0;
      req_ch.sample <= '0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      hold_request    = 1'b0;
      failures        = 0;
      old_rows_in_use = 1;
      old_cols_in_use = 1;
      new_rows_in_use = 1;
      new_cols_in_use = 1;
      foreach (shadow_written[n]) shadow_written[n] = 1'b0;

      directed_steps = '{
         item_step(aamr_pkg::KIND_WRITE, 0, 0, 32767, 1, 0, 0),
         item_step(aamr_pkg::KIND_READ, 0, 0, 0, 1, 8388352, 0),
         item_step(aamr_pkg::KIND_WRITE, 0, 0, -32768, 1, 0, 0),
         item_step(aamr_pkg::KIND_READ, 0, 0, 0, 1, -8388608, 0),
         item_step(aamr_pkg::KIND_WRITE, 0, 1, 'h5555, 1, 0, 1),
         item_step(aamr_pkg::KIND_WRITE, 63, 63, 'haaaa, 1, 0, 1),
         item_step(aamr_pkg::KIND_READ, 0, 1, 0, 1, 0, 1),
         item_step(aamr_pkg::KIND_READ, 63, 0, 0, 1, 0, 1),
         item_step(aamr_pkg::KIND_WRITE, 0, 0, 0, 1, 0, 0),
         item_step(aamr_pkg::KIND_READ, 0, 0, 0, 1, 0, 0),
         // A zero dimension acts as one; 127 is clamped to the maximum.
         reg_step(aamr_pkg::REG_OLD_ROWS, 0),
         reg_step(aamr_pkg::REG_OLD_COLS, 3),
         reg_step(aamr_pkg::REG_NEW_ROWS, 127),
         reg_step(aamr_pkg::REG_NEW_COLS, 2),
         item_step(aamr_pkg::KIND_WRITE, 0, 0, 100, 0, 0, 0),
         item_step(aamr_pkg::KIND_WRITE, 0, 1, -7, 0, 0, 0),
         item_step(aamr_pkg::KIND_WRITE, 0, 2, 32767, 0, 0, 0),
         item_step(aamr_pkg::KIND_WRITE, 1, 0, 5, 1, 0, 1),
         item_step(aamr_pkg::KIND_READ, 63, 1, 0, 0, 0, 0),
         item_step(aamr_pkg::KIND_READ, 0, 0, 0, 0, 0, 0),
         item_step(aamr_pkg::KIND_READ, 31, 0, 0, 0, 0, 0),
         item_step(aamr_pkg::KIND_READ, 0, 2, 0, 1, 0, 1)
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_steps[n]) begin
         if (directed_steps[n].is_cfg) begin
            await_drain();
            write_reg(directed_steps[n].reg_sel, directed_steps[n].reg_data);
         end else begin
            send_item(directed_steps[n].kind, directed_steps[n].row, directed_steps[n].col,
                      directed_steps[n].sample, directed_steps[n].typed,
                      directed_steps[n].value, directed_steps[n].range_error);
         end
      end

      run_phase(3, 4, 2, 7, 0, 0, 12, 1'b0);
      run_phase(3, 3, 3, 3, 76, 0, 12, 1'b0);
      run_phase(2, 2, 64, 64, 0, 76, 12, 1'b0);
      run_phase(5, 3, 9, 1, 7, 7, 12, 1'b0);
      // The receiver holds off for a long stretch here while items keep coming.
      run_phase(3, 6, 1, 6, 0, 0, 12, 1'b1);
      run_phase($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 6),
                $urandom_range(1, 6), 0, 76, 12, 1'b0);
      run_phase($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 6),
                $urandom_range(1, 6), 76, 0, 12, 1'b0);
      run_phase(5, 6, 1, 1, 7, 7, 12, 1'b0);

      await_drain();
      repeat (200) @(posedge clock);
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
